/* rtl/rmst_pkg.sv */
// Shared types, constants and helper functions for the range-maximum sparse table.
`default_nettype none

package rmst_pkg;

   localparam int DepthDefault  = 1024;
   localparam int LevelsDefault = 11;

   localparam int CountWidth = 11;
   localparam int IndexWidth = 10;
   localparam int ValueWidth = 32;
   localparam int LogWidth   = 4;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_BUILD = 2'd1,
      CMD_QUERY = 2'd2
   } command_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_QUERY_READ,
      ST_QUERY_DONE,
      ST_BUILD_LEVEL,
      ST_BUILD_STEP,
      ST_BUILD_DRAIN
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic build_start;
      logic level_init;
      logic step;
      logic level_next;
      logic set_built;
      logic query_latch;
      logic query_read;
      logic result_load;
   } ctrl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic level_done;
      logic last_step;
      logic out_free;
   } status_type;

   function automatic logic [ValueWidth-1:0] smax(input logic [ValueWidth-1:0] a,
                                                  input logic [ValueWidth-1:0] b);
      smax = ($signed(a) >= $signed(b)) ? a : b;
   endfunction

   // Position of the highest set bit; the argument is never zero when it matters.
   function automatic logic [LogWidth-1:0] floor_log2(input logic [CountWidth-1:0] x);
      logic [LogWidth-1:0] k;
      k = '0;
      for (int i = 0; i < CountWidth; i++) begin
         if (x[i]) k = LogWidth'(i);
      end
      floor_log2 = k;
   endfunction

endpackage

`default_nettype wire

/* rtl/rmst_ram.sv */
// Generic RAM with one write port and two registered read ports.
`default_nettype none

module rmst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem[rd_addr_a];
         rd_data_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

`default_nettype wire

/* rtl/rmst_ctrl.sv */
// Controller state machine sequencing loads, queries and the table build.
`default_nettype none

module rmst_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic [1:0]           req_command,
   output logic                      req_stall,
   input  wire rmst_pkg::status_type status,
   output rmst_pkg::ctrl_type        ctrl
);

   rmst_pkg::state_type state_ff;
   rmst_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rmst_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctrl      = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         rmst_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               unique case (req_command)
                  rmst_pkg::CMD_LOAD: begin
                     ctrl.load = 1'b1;
                  end
                  rmst_pkg::CMD_BUILD: begin
                     ctrl.build_start = 1'b1;
                     state_in         = rmst_pkg::ST_BUILD_LEVEL;
                  end
                  rmst_pkg::CMD_QUERY: begin
                     ctrl.query_latch = 1'b1;
                     state_in         = rmst_pkg::ST_QUERY_READ;
                  end
                  default: begin
                     // The unused command is taken and dropped.
                  end
               endcase
            end
         end
         rmst_pkg::ST_QUERY_READ: begin
            ctrl.query_read = 1'b1;
            state_in        = rmst_pkg::ST_QUERY_DONE;
         end
         rmst_pkg::ST_QUERY_DONE: begin
            if (status.out_free) begin
               ctrl.result_load = 1'b1;
               state_in         = rmst_pkg::ST_IDLE;
            end
         end
         rmst_pkg::ST_BUILD_LEVEL: begin
            if (status.level_done) begin
               ctrl.set_built = 1'b1;
               state_in       = rmst_pkg::ST_IDLE;
            end else begin
               ctrl.level_init = 1'b1;
               state_in        = rmst_pkg::ST_BUILD_STEP;
            end
         end
         rmst_pkg::ST_BUILD_STEP: begin
            ctrl.step = 1'b1;
            if (status.last_step) begin
               state_in = rmst_pkg::ST_BUILD_DRAIN;
            end
         end
         rmst_pkg::ST_BUILD_DRAIN: begin
            // The last write of the level lands here, before the next level reads it.
            ctrl.level_next = 1'b1;
            state_in        = rmst_pkg::ST_BUILD_LEVEL;
         end
         default: begin
            state_in = rmst_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/rmst_dpath.sv */
// Datapath: table memory, build counters, query addressing and result register.
`default_nettype none

module rmst_dpath #(
   parameter int DEPTH  = rmst_pkg::DepthDefault,
   parameter int LEVELS = rmst_pkg::LevelsDefault
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire rmst_pkg::ctrl_type                  ctrl,
   output rmst_pkg::status_type                     status,
   input  wire logic                                csr_write_enable,
   input  wire logic [rmst_pkg::CountWidth-1:0]     csr_write_data,
   input  wire logic [rmst_pkg::IndexWidth-1:0]     req_left_index,
   input  wire logic [rmst_pkg::IndexWidth-1:0]     req_right_index,
   input  wire logic signed [rmst_pkg::ValueWidth-1:0] req_value,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [rmst_pkg::ValueWidth-1:0]   rsp_maximum,
   output logic                                     rsp_range_error
);

   localparam int CW       = rmst_pkg::CountWidth;
   localparam int XW       = rmst_pkg::IndexWidth;
   localparam int VW       = rmst_pkg::ValueWidth;
   localparam int IW       = $clog2(DEPTH);
   localparam int LW       = $clog2(LEVELS);
   localparam int KW       = $clog2(LEVELS + 1);
   localparam int AW       = LW + IW;
   localparam int MemDepth = LEVELS * (2 ** IW);

   logic [CW-1:0] count_ff;
   logic          built_ff;
   logic [CW-1:0] n_ff;
   logic [KW-1:0] level_ff;
   logic [CW:0]   span_ff;
   logic [XW-1:0] idx_ff;
   logic [XW-1:0] q_left_ff;
   logic [XW-1:0] q_right_ff;
   logic          q_err_ff;
   logic          wr_pend_ff;
   logic [AW-1:0] wr_addr_ff;
   logic          rsp_valid_ff;
   logic [VW-1:0] rsp_maximum_ff;
   logic          rsp_error_ff;

   logic [CW-1:0] eff_count;
   logic          load_ok;
   logic [CW-1:0] q_len;
   logic [rmst_pkg::LogWidth-1:0] q_level;
   logic [CW-1:0] q_pow;
   logic [CW-1:0] q_idx_b;
   logic          q_err;
   logic [CW-1:0] idx_half;

   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic [VW-1:0] mem_wr_data;
   logic          mem_rd_en;
   logic [AW-1:0] mem_rd_addr_a;
   logic [AW-1:0] mem_rd_addr_b;
   logic [VW-1:0] mem_rd_data_a;
   logic [VW-1:0] mem_rd_data_b;
   logic [VW-1:0] pair_max;

   // Element count saturated to the table depth.
   assign eff_count = (32'(count_ff) > 32'(DEPTH)) ? CW'(DEPTH) : count_ff;
   assign load_ok   = 32'(req_left_index) < 32'(DEPTH);

   assign q_len   = {1'b0, q_right_ff} - {1'b0, q_left_ff} + CW'(1);
   assign q_level = rmst_pkg::floor_log2(q_len);
   assign q_pow   = CW'(1) << q_level;
   assign q_idx_b = {1'b0, q_right_ff} + CW'(1) - q_pow;
   assign q_err   = !built_ff || (q_left_ff > q_right_ff)
                    || ({1'b0, q_right_ff} >= eff_count)
                    || (32'(q_level) > 32'(LEVELS - 1));

   assign idx_half = {1'b0, idx_ff} + CW'(span_ff >> 1);

   assign status.level_done = (level_ff > KW'(LEVELS - 1)) || (span_ff > {1'b0, n_ff});
   assign status.last_step  = ({2'b00, idx_ff} + span_ff) == {1'b0, n_ff};
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   assign pair_max = rmst_pkg::smax(mem_rd_data_a, mem_rd_data_b);

   always_comb begin
      mem_wr_en   = wr_pend_ff || (ctrl.load && load_ok);
      mem_wr_addr = wr_pend_ff ? wr_addr_ff : {LW'(0), IW'(req_left_index)};
      mem_wr_data = wr_pend_ff ? pair_max : req_value;
      mem_rd_en   = ctrl.step || ctrl.query_read;
      if (ctrl.query_read) begin
         mem_rd_addr_a = {LW'(q_level), IW'(q_left_ff)};
         mem_rd_addr_b = {LW'(q_level), IW'(q_idx_b)};
      end else begin
         mem_rd_addr_a = {LW'(level_ff - KW'(1)), IW'(idx_ff)};
         mem_rd_addr_b = {LW'(level_ff - KW'(1)), IW'(idx_half)};
      end
   end

   rmst_ram #(
      .WIDTH(VW),
      .DEPTH(MemDepth)
   ) u_table (
      .clock     (clock),
      .wr_en     (mem_wr_en),
      .wr_addr   (mem_wr_addr),
      .wr_data   (mem_wr_data),
      .rd_en     (mem_rd_en),
      .rd_addr_a (mem_rd_addr_a),
      .rd_addr_b (mem_rd_addr_b),
      .rd_data_a (mem_rd_data_a),
      .rd_data_b (mem_rd_data_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= CW'(1);
         built_ff     <= 1'b0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            count_ff <= csr_write_data;
            built_ff <= 1'b0;
         end else if (ctrl.load && load_ok) begin
            built_ff <= 1'b0;
         end else if (ctrl.set_built) begin
            built_ff <= 1'b1;
         end
         wr_pend_ff <= ctrl.step;
         if (ctrl.result_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.build_start) begin
         n_ff     <= eff_count;
         level_ff <= KW'(1);
         span_ff  <= (CW + 1)'(2);
      end else if (ctrl.level_next) begin
         level_ff <= level_ff + KW'(1);
         span_ff  <= span_ff << 1;
      end
      if (ctrl.level_init) begin
         idx_ff <= '0;
      end else if (ctrl.step) begin
         idx_ff <= idx_ff + XW'(1);
      end
      if (ctrl.step) begin
         wr_addr_ff <= {LW'(level_ff), IW'(idx_ff)};
      end
      if (ctrl.query_latch) begin
         q_left_ff  <= req_left_index;
         q_right_ff <= req_right_index;
      end
      if (ctrl.query_read) begin
         q_err_ff <= q_err;
      end
      if (ctrl.result_load) begin
         rsp_maximum_ff <= q_err_ff ? '0 : pair_max;
         rsp_error_ff   <= q_err_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_maximum     = rsp_maximum_ff;
   assign rsp_range_error = rsp_error_ff;

endmodule

`default_nettype wire

/* rtl/range_max_sparse_table.sv */
// Load: one transaction per cycle while idle. Query: the indices are latched on acceptance,
// the two table entries are then read from the registered RAM, and the result is registered
// once the output is free, after which a new query is taken. Build: each level has a setup
// state, one step per entry written and a drain state; input is stalled while a
// query or build is in progress. Reset is synchronous: element_count returns to 1 and the
// table is marked not built; table contents are not cleared.
`default_nettype none

module range_max_sparse_table #(
   parameter int DEPTH  = rmst_pkg::DepthDefault,
   parameter int LEVELS = rmst_pkg::LevelsDefault
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_write_enable,
   input  wire logic [rmst_pkg::CountWidth-1:0]        csr_write_data,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic [1:0]                             req_command,
   input  wire logic [rmst_pkg::IndexWidth-1:0]        req_left_index,
   input  wire logic [rmst_pkg::IndexWidth-1:0]        req_right_index,
   input  wire logic signed [rmst_pkg::ValueWidth-1:0] req_value,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic signed [rmst_pkg::ValueWidth-1:0]      rsp_maximum,
   output logic                                        rsp_range_error
);

   rmst_pkg::ctrl_type   ctrl;
   rmst_pkg::status_type status;

   rmst_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .status      (status),
      .ctrl        (ctrl)
   );

   rmst_dpath #(
      .DEPTH  (DEPTH),
      .LEVELS (LEVELS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_left_index   (req_left_index),
      .req_right_index  (req_right_index),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_maximum      (rsp_maximum),
      .rsp_range_error  (rsp_range_error)
   );

endmodule

`default_nettype wire
